// ===== hdl/i2fic_pkg.sv =====
// Shared types and constants for the integer-to-float image converter.
// No dependencies.
package i2fic_pkg;

  // Biases and ranges for the integer and narrowing paths.
  localparam int IeeeIntBias = 1023 + 52;
  localparam int DecIntBias  = 128 + 56;
  localparam int IeeeRebias  = 127 - 1023;
  localparam int IeeeExpBase = IeeeIntBias - 52;  // exponent for leading one at bit 0
  localparam int DecExpBase  = DecIntBias - 55;   // 0.1f form: 129 for leading one at bit 0
  localparam int NarrowExpLo = 1 - IeeeRebias;    // lowest wide exponent that fits
  localparam int NarrowExpHi = 254 - IeeeRebias;  // highest wide exponent that fits

  localparam logic [3:0] ByteCountSingle = 4'd4;
  localparam logic [3:0] ByteCountDouble = 4'd8;

  // Configured float format.
  localparam logic FmtDec  = 1'b0;
  localparam logic FmtIeee = 1'b1;

  // Operation codes.
  localparam logic OpConvert = 1'b0;
  localparam logic OpImage   = 1'b1;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    logic        use_image;
    logic        single;
    logic        ieee;
    logic        sign;
    logic        zero;
    logic [31:0] mag;
    logic [4:0]  lead;
    logic [63:0] image;
  } i2fic_item_t;

endpackage

// ===== hdl/i2fic_front.sv =====
// Front end: holds the format register, accepts items and classifies them
// (sign, magnitude, leading-one position). Depends on i2fic_pkg.
module i2fic_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_write_en,
  input  logic                     cfg_float_format,
  input  logic                     in_operation,
  input  logic signed [31:0]       in_int_value,
  input  logic [63:0]              in_float_image,
  input  logic                     in_single_target,
  output i2fic_pkg::i2fic_item_t   item
);

  logic        fmt_r;
  logic        sign;
  logic [31:0] mag;
  logic [4:0]  lead;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= i2fic_pkg::FmtDec;
    end else if (cfg_write_en) begin
      fmt_r <= cfg_float_format;
    end
  end

  // Magnitude; the most negative value wraps to 2^31, which is exact.
  assign sign = in_int_value[31];
  assign mag  = sign ? (~in_int_value + 32'd1) : in_int_value;

  // Leading-one encoder, highest set bit wins.
  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lead = 5'(i);
    end
  end

  always_comb begin
    item.use_image = (in_operation == i2fic_pkg::OpImage);
    item.single    = in_single_target;
    item.ieee      = (fmt_r == i2fic_pkg::FmtIeee);
    item.sign      = sign;
    item.zero      = (mag == 32'd0);
    item.mag       = mag;
    item.lead      = lead;
    item.image     = in_float_image;
  end

endmodule

// ===== hdl/i2fic_queue.sv =====
// Small FIFO of classified items between front and back ends.
// Depends on i2fic_pkg.
module i2fic_queue #(
  parameter int Depth = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  i2fic_pkg::i2fic_item_t push_item,
  input  logic                   pop,
  output i2fic_pkg::i2fic_item_t head_item,
  output logic                   empty,
  output logic                   full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  i2fic_pkg::i2fic_item_t mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == CntW'(0));
  assign full    = (count_r == CntW'(Depth));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/i2fic_back.sv =====
// Back end: normalizes, packs and optionally narrows one item per cycle,
// and registers the result with its strobe. Depends on i2fic_pkg.
module i2fic_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  input  i2fic_pkg::i2fic_item_t item,
  output logic                   out_strobe,
  output logic [63:0]            out_result_image,
  output logic [3:0]             out_byte_count,
  output logic                   out_exponent_range_error
);

  logic        strobe_r;
  logic [63:0] image_r, image_nxt;
  logic [3:0]  count_r, count_nxt;
  logic        err_r, err_nxt;

  logic [31:0] norm;
  logic [10:0] ieee_exp;
  logic [7:0]  dec_exp;
  logic [63:0] wide_img;
  logic [63:0] img;
  logic [10:0] wide_exp;
  logic [11:0] rebiased;
  logic [7:0]  narrow_exp;
  logic        range_bad;

  always_comb begin
    // Shift leading one up to bit 31; the hidden bit then drops off.
    norm     = item.mag << (~item.lead);
    ieee_exp = 11'(i2fic_pkg::IeeeExpBase) + 11'(item.lead);
    dec_exp  = 8'(i2fic_pkg::DecExpBase) + 8'(item.lead);
    if (item.zero) begin
      wide_img = '0;
    end else if (item.ieee) begin
      wide_img = {item.sign, ieee_exp, norm[30:0], 21'd0};
    end else begin
      wide_img = {item.sign, dec_exp, norm[30:0], 24'd0};
    end
    img = item.use_image ? item.image : wide_img;

    // IEEE single narrowing: rebias, wrap to 8 bits, flag out-of-range.
    wide_exp   = img[62:52];
    rebiased   = {1'b0, wide_exp} + 12'(i2fic_pkg::IeeeRebias);
    range_bad  = (wide_exp != 11'd0) &&
                 ((wide_exp < 11'(i2fic_pkg::NarrowExpLo)) ||
                  (wide_exp > 11'(i2fic_pkg::NarrowExpHi)));
    narrow_exp = (wide_exp == 11'd0) ? 8'd0 : rebiased[7:0];

    image_nxt = img;
    count_nxt = i2fic_pkg::ByteCountDouble;
    err_nxt   = 1'b0;
    if (item.single) begin
      count_nxt = i2fic_pkg::ByteCountSingle;
      if (item.ieee) begin
        image_nxt = {img[63], narrow_exp, img[51:29], 32'd0};
        err_nxt   = range_bad;
      end else begin
        image_nxt = {img[63:32], 32'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      image_r <= image_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_strobe               = strobe_r;
  assign out_result_image         = image_r;
  assign out_byte_count           = count_r;
  assign out_exponent_range_error = err_r;

endmodule

// ===== hdl/int32_to_float_image_converter.sv =====
// Integer-to-float image converter, top level.
// An accepted item is written into the queue, then registered by the back end with its strobe.
// Throughput: one item per cycle; the back end drains the queue every cycle,
// so busy stays low in normal operation and the result strobe cannot be held.
// Reset (rst_n low, synchronous): format = DEC, queue emptied, strobe low, busy high.
// Depends on i2fic_pkg, i2fic_front, i2fic_queue, i2fic_back.
module int32_to_float_image_converter #(
  parameter int QueueDepth = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_write_en,
  input  logic               cfg_float_format,
  // item input
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic signed [31:0] in_int_value,
  input  logic [63:0]        in_float_image,
  input  logic               in_single_target,
  // results
  output logic               out_strobe,
  output logic [63:0]        out_result_image,
  output logic [3:0]         out_byte_count,
  output logic               out_exponent_range_error
);

  i2fic_pkg::i2fic_item_t front_item;
  i2fic_pkg::i2fic_item_t head_item;
  logic                   q_empty;
  logic                   q_full;
  logic                   accept;

  // An item is taken when start is high and the queue has room.
  // Busy also stays high while reset is asserted, so no item is taken then.
  assign busy   = q_full || !rst_n;
  assign accept = start && !busy;

  // Front end: format register plus sign/magnitude/leading-one classify.
  i2fic_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_float_format (cfg_float_format),
    .in_operation     (in_operation),
    .in_int_value     (in_int_value),
    .in_float_image   (in_float_image),
    .in_single_target (in_single_target),
    .item             (front_item)
  );

  // Decoupling queue; popped whenever it holds an item.
  i2fic_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (front_item),
    .pop       (!q_empty),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back end: barrel shift, pack, narrow, output register.
  i2fic_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .item_valid               (!q_empty),
    .item                     (head_item),
    .out_strobe               (out_strobe),
    .out_result_image         (out_result_image),
    .out_byte_count           (out_byte_count),
    .out_exponent_range_error (out_exponent_range_error)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for int32_to_float_image_converter (integer and
// image paths, IEEE and DEC packing, single narrowing). Needs i2fic_pkg and the RTL.
module tb;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 125;
  localparam int CycleLimit    = 400000;
  localparam int MaxPrinted    = 40;
  localparam int SettleCycles  = 8;
  localparam int DirRows       = 25;

  // One result as the block presents it.
  typedef struct packed {
    logic [63:0] image;
    logic [3:0]  count;
    logic        flag;
  } conv_res_t;

  // One directed row: format to run under, item fields and, where it is
  // obvious from the format rules, the typed-in result.
  typedef struct packed {
    logic        fmt;
    logic        op;
    logic [31:0] ival;
    logic [63:0] fimg;
    logic        single;
    logic        typed;
    conv_res_t   want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_write_en = 1'b0;
  logic               cfg_float_format = i2fic_pkg::FmtDec;
  logic               start = 1'b0;
  logic               busy;
  logic               in_operation = i2fic_pkg::OpConvert;
  logic signed [31:0] in_int_value = '0;
  logic [63:0]        in_float_image = '0;
  logic               in_single_target = 1'b0;
  logic               out_strobe;
  logic [63:0]        out_result_image;
  logic [3:0]         out_byte_count;
  logic               out_exponent_range_error;

  // Format the predictor assumes; follows every register write.
  logic      cur_fmt = i2fic_pkg::FmtDec;
  conv_res_t pending_results[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        n_items = 0;
  int        n_convert = 0;
  int        n_single = 0;
  int        n_wraps = 0;
  int        n_checked = 0;
  int        n_fmt_writes = 0;

  int32_to_float_image_converter DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_write_en             (cfg_write_en),
    .cfg_float_format         (cfg_float_format),
    .start                    (start),
    .busy                     (busy),
    .in_operation             (in_operation),
    .in_int_value             (in_int_value),
    .in_float_image           (in_float_image),
    .in_single_target         (in_single_target),
    .out_strobe               (out_strobe),
    .out_result_image         (out_result_image),
    .out_byte_count           (out_byte_count),
    .out_exponent_range_error (out_exponent_range_error)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Expected image for one item under the given format.
  // Integers: magnitude, leading one, shift into the fraction, drop the hidden bit.
  // Narrowing: IEEE rebiases the 11-bit exponent and keeps the low 8 bits of it,
  // flagging anything outside 1..254 (a zero exponent stays zero, no flag);
  // DEC just keeps the upper word.
  function automatic conv_res_t predict_image(input logic fmt, input logic op,
                                              input logic [31:0] ival,
                                              input logic [63:0] fimg,
                                              input logic single);
    conv_res_t   r;
    logic [31:0] mag;
    logic [63:0] img;
    logic [63:0] wide;
    logic [10:0] e11;
    logic [7:0]  e8;
    int          lead;
    int          rexp;
    int          b;
    img = fimg;
    r.flag = 1'b0;
    if (op == i2fic_pkg::OpConvert) begin
      mag = ival[31] ? (~ival + 32'd1) : ival;
      img = '0;
      if (mag != 32'd0) begin
        lead = 0;
        for (b = 0; b < 32; b++) begin
          if (mag[b]) lead = b;
        end
        wide = {32'd0, mag};
        if (fmt == i2fic_pkg::FmtIeee) begin
          e11 = 11'(i2fic_pkg::IeeeExpBase + lead);
          wide = wide << (52 - lead);
          img = {ival[31], e11, wide[51:0]};
        end else begin
          e8 = 8'(i2fic_pkg::DecExpBase + lead);
          wide = wide << (55 - lead);
          img = {ival[31], e8, wide[54:0]};
        end
      end
    end
    if (single) begin
      if (fmt == i2fic_pkg::FmtIeee) begin
        rexp = int'(img[62:52]);
        if (rexp != 0) begin
          rexp = rexp + i2fic_pkg::IeeeRebias;
          if (rexp < 1 || rexp > 254) r.flag = 1'b1;
        end
        e8 = rexp[7:0];
        img = {img[63], e8, img[51:29], 32'd0};
      end else begin
        img = {img[63:32], 32'd0};
      end
    end
    r.image = img;
    r.count = single ? i2fic_pkg::ByteCountSingle : i2fic_pkg::ByteCountDouble;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic fmt, input logic op,
                                      input logic [31:0] ival, input logic [63:0] fimg,
                                      input logic single, input logic typed,
                                      input logic [63:0] img, input logic [3:0] cnt,
                                      input logic flag);
    stim_row_t r;
    r.fmt = fmt;
    r.op = op;
    r.ival = ival;
    r.fimg = fimg;
    r.single = single;
    r.typed = typed;
    r.want.image = img;
    r.want.count = cnt;
    r.want.flag = flag;
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    if (err_cnt <= MaxPrinted)
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  // Present one item and hold it until the block takes it. Returns at the
  // accepting edge without touching start, so the caller may chain the next one.
  task automatic send_item(input logic op, input logic [31:0] ival,
                           input logic [63:0] fimg, input logic single,
                           input logic typed, input conv_res_t typed_res);
    conv_res_t want;
    start <= 1'b1;
    in_operation <= op;
    in_int_value <= ival;
    in_float_image <= fimg;
    in_single_target <= single;
    do @(posedge clk); while (busy !== 1'b0);
    want = typed ? typed_res : predict_image(cur_fmt, op, ival, fimg, single);
    pending_results.push_back(want);
    n_items++;
    if (op == i2fic_pkg::OpConvert) n_convert++;
    if (single) n_single++;
    if (want.flag) n_wraps++;
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop sending and let every outstanding item come back; every item makes
  // exactly one result.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_format(input logic fmt);
    cfg_write_en <= 1'b1;
    cfg_float_format <= fmt;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_fmt = fmt;
    n_fmt_writes++;
  endtask

  // Result side: the block cannot be held off, so every strobe is checked
  // against the oldest expectation on the edge that ends it.
  always @(posedge clk) begin
    conv_res_t want;
    if (rst_n && out_strobe !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding", out_result_image, '0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_result_image !== want.image)
          report_mismatch("result_image", out_result_image, want.image);
        if (out_byte_count !== want.count)
          report_mismatch("byte_count", 64'(out_byte_count), 64'(want.count));
        if (out_exponent_range_error !== want.flag)
          report_mismatch("exponent_range_error", 64'(out_exponent_range_error),
                          64'(want.flag));
      end
    end
  end

  // Watchdog: a correct run, even with every gap at its longest, stays far below this.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL int32_to_float_image_converter");
    $finish;
  end

  initial begin
    stim_row_t   dir_tab[DirRows];
    logic        op;
    logic        single;
    logic        fmt0;
    logic        no_gaps;
    logic [31:0] ival;
    logic [63:0] fimg;
    int          sel;
    int          i;
    int          k;

    // Directed rows. DEC first (the reset format), then IEEE, then DEC again.
    // Zero, one, the extremes of int32, narrowing at the exponent edges,
    // infinity, subnormals, NaN pass-through and ignored fields.
    dir_tab[0]  = mk_row(i2fic_pkg::FmtDec, i2fic_pkg::OpConvert, 32'd0, '1, 1'b0,
                         1'b1, 64'h0, i2fic_pkg::ByteCountDouble, 1'b0);
    dir_tab[1]  = mk_row(i2fic_pkg::FmtDec, i2fic_pkg::OpConvert, 32'd1, '0, 1'b0,
                         1'b1, 64'h4080_0000_0000_0000, i2fic_pkg::ByteCountDouble, 1'b0);
    dir_tab[2]  = mk_row(i2fic_pkg::FmtDec, i2fic_pkg::OpConvert, 32'h8000_0000, '0, 1'b0,
                         1'b1, 64'hD000_0000_0000_0000, i2fic_pkg::ByteCountDouble, 1'b0);
    dir_tab[3]  = mk_row(i2fic_pkg::FmtDec, i2fic_pkg::OpConvert, 32'h1234_5678, '0, 1'b0,
                         1'b0, '0, '0, 1'b0);
    dir_tab[4]  = mk_row(i2fic_pkg::FmtDec, i2fic_pkg::OpConvert, -32'sd123456, '1, 1'b1,
                         1'b0, '0, '0, 1'b0);
    dir_tab[5]  = mk_row(i2fic_pkg::FmtDec, i2fic_pkg::OpImage, 32'hFFFF_FFFF, '1, 1'b1,
                         1'b1, 64'hFFFF_FFFF_0000_0000, i2fic_pkg::ByteCountSingle, 1'b0);
    dir_tab[6]  = mk_row(i2fic_pkg::FmtDec, i2fic_pkg::OpImage, 32'd0,
                         64'h7FF8_0000_0000_0001, 1'b0,
                         1'b1, 64'h7FF8_0000_0000_0001, i2fic_pkg::ByteCountDouble, 1'b0);
    dir_tab[7]  = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpConvert, 32'd0, '0, 1'b1,
                         1'b1, 64'h0, i2fic_pkg::ByteCountSingle, 1'b0);
    dir_tab[8]  = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpConvert, 32'd1, '0, 1'b0,
                         1'b1, 64'h3FF0_0000_0000_0000, i2fic_pkg::ByteCountDouble, 1'b0);
    dir_tab[9]  = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpConvert, 32'hFFFF_FFFF, '0, 1'b0,
                         1'b1, 64'hBFF0_0000_0000_0000, i2fic_pkg::ByteCountDouble, 1'b0);
    dir_tab[10] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpConvert, 32'h8000_0000, '0, 1'b0,
                         1'b1, 64'hC1E0_0000_0000_0000, i2fic_pkg::ByteCountDouble, 1'b0);
    dir_tab[11] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpConvert, 32'h7FFF_FFFF, '0, 1'b0,
                         1'b1, 64'h41DF_FFFF_FFC0_0000, i2fic_pkg::ByteCountDouble, 1'b0);
    // infinity narrows to a wrapped exponent and raises the flag
    dir_tab[12] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpImage, 32'd0,
                         64'h7FF0_0000_0000_0000, 1'b1,
                         1'b1, 64'h3F80_0000_0000_0000, i2fic_pkg::ByteCountSingle, 1'b1);
    dir_tab[13] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpImage, 32'd0,
                         64'h3FF0_0000_0000_0000, 1'b1,
                         1'b1, 64'h3F80_0000_0000_0000, i2fic_pkg::ByteCountSingle, 1'b0);
    // subnormal: exponent stays zero, fraction truncated, no flag
    dir_tab[14] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpImage, 32'd0,
                         64'h000F_FFFF_FFFF_FFFF, 1'b1,
                         1'b1, 64'h007F_FFFF_0000_0000, i2fic_pkg::ByteCountSingle, 1'b0);
    dir_tab[15] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpImage, 32'd0,
                         64'h0010_0000_0000_0000, 1'b1,
                         1'b1, 64'h4080_0000_0000_0000, i2fic_pkg::ByteCountSingle, 1'b1);
    // lowest and highest wide exponents that still fit, and one past each
    dir_tab[16] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpImage, 32'd0,
                         64'h3810_0000_0000_0000, 1'b1,
                         1'b1, 64'h0080_0000_0000_0000, i2fic_pkg::ByteCountSingle, 1'b0);
    dir_tab[17] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpImage, 32'd0,
                         64'h47E0_0000_0000_0000, 1'b1,
                         1'b1, 64'h7F00_0000_0000_0000, i2fic_pkg::ByteCountSingle, 1'b0);
    dir_tab[18] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpImage, 32'd0,
                         64'h47F0_0000_0000_0000, 1'b1,
                         1'b1, 64'h7F80_0000_0000_0000, i2fic_pkg::ByteCountSingle, 1'b1);
    dir_tab[19] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpImage, 32'd0,
                         64'hB800_0000_0000_0000, 1'b1,
                         1'b1, 64'h8000_0000_0000_0000, i2fic_pkg::ByteCountSingle, 1'b1);
    dir_tab[20] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpImage, 32'h7FFF_FFFF, '1, 1'b0,
                         1'b1, '1, i2fic_pkg::ByteCountDouble, 1'b0);
    dir_tab[21] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpConvert, 32'd1, '1, 1'b1,
                         1'b1, 64'h3F80_0000_0000_0000, i2fic_pkg::ByteCountSingle, 1'b0);
    dir_tab[22] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpConvert, 32'h00AB_CDEF, '0, 1'b1,
                         1'b0, '0, '0, 1'b0);
    dir_tab[23] = mk_row(i2fic_pkg::FmtIeee, i2fic_pkg::OpConvert, -32'sd7, '0, 1'b0,
                         1'b0, '0, '0, 1'b0);
    dir_tab[24] = mk_row(i2fic_pkg::FmtDec, i2fic_pkg::OpConvert, 32'h7FFF_FFFF, '0, 1'b1,
                         1'b0, '0, '0, 1'b0);

    // Synchronous reset, then release.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: format changes only with nothing in flight.
    for (i = 0; i < DirRows; i++) begin
      if (dir_tab[i].fmt != cur_fmt) begin
        wait_idle();
        write_format(dir_tab[i].fmt);
      end
      send_item(dir_tab[i].op, dir_tab[i].ival, dir_tab[i].fimg, dir_tab[i].single,
                dir_tab[i].typed, dir_tab[i].want);
      idle_gap(pick_gap());
    end

    // Random part: phases alternate the format, some phases run without gaps.
    fmt0 = 1'($urandom_range(0, 1));
    for (k = 0; k < NumPhases; k++) begin
      wait_idle();
      write_format(fmt0 ^ k[0]);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (i = 0; i < ItemsPerPhase; i++) begin
        op = 1'($urandom_range(0, 1));
        single = 1'($urandom_range(0, 1));
        // integers of every size, both signs, with the extremes mixed in
        sel = $urandom_range(0, 9);
        ival = $urandom;
        if (sel < 6) ival = ival >> $urandom_range(0, 31);
        if (sel < 4 && $urandom_range(0, 1)) ival = -ival;
        if (sel == 6) ival = 32'h8000_0000;
        if (sel == 7) ival = 32'd0;
        // images: random, or exponents pushed to the narrowing edges
        fimg = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel < 4)
          fimg[62:52] = 11'($urandom_range(i2fic_pkg::NarrowExpLo - 12,
                                           i2fic_pkg::NarrowExpLo + 4));
        else if (sel < 7)
          fimg[62:52] = 11'($urandom_range(i2fic_pkg::NarrowExpHi - 4,
                                           i2fic_pkg::NarrowExpHi + 12));
        else if (sel == 7) fimg[62:52] = '0;
        else if (sel == 8) fimg[62:52] = '1;
        send_item(op, ival, fimg, single, 1'b0, '0);
        if (!no_gaps) idle_gap(pick_gap());
      end
    end

    // Drain, then give any stray result time to show up.
    wait_idle();
    repeat (SettleCycles) @(posedge clk);

    $display("Ran %0d items (%0d integer conversions, %0d narrowed, %0d exponent wraps),",
             n_items, n_convert, n_single, n_wraps);
    $display("%0d results checked across %0d format writes, %0d mismatches.",
             n_checked, n_fmt_writes, err_cnt);
    if (err_cnt == 0)
      $display("PASS int32_to_float_image_converter");
    else
      $display("FAIL int32_to_float_image_converter");
    $finish;
  end

endmodule
